// File: rtl/soa_pkg.sv
`timescale 1ns / 1ps
// soa_pkg: shared widths, constants, beat types, FSM states and radius tables
// for the sphere overlap accumulator. No dependencies.
package soa_pkg;

  localparam int CoordFracBits = 8;
  localparam int CoordW        = 20;
  localparam int DiffW         = CoordW + 1;
  localparam int SmallW        = CoordFracBits + 3;
  localparam int D2W           = 2 * SmallW + 2;
  localparam int CmpW          = 2 * CoordFracBits + 15;
  localparam int SqrtInW       = 38;
  localparam int SqrtShift     = 32 - 2 * CoordFracBits;
  localparam int RootW         = SqrtInW / 2;
  localparam int RootCntW      = $clog2(RootW + 1);
  localparam int AdqW          = RootW + 6;
  localparam int MulAW         = 48;
  localparam int MulBW         = 24;
  localparam int MulPW         = 64;
  localparam int DivNW         = 48;
  localparam int DivDW         = 26;
  localparam int DivCntW       = $clog2(DivNW + 1);
  localparam int NumW          = 48;
  localparam int InnerW        = 32;
  localparam int SumW          = 48;
  localparam int InvW          = 16;
  localparam int OutW          = 32;
  localparam int TwoPiW        = 23;

  localparam logic [TwoPiW-1:0] TwoPiQ20 = TwoPiW'(6588397);
  localparam logic [InvW-1:0]   InvReset = InvW'(4096);
  localparam logic signed [DiffW-1:0] DxLimit = DiffW'(2 << CoordFracBits);
  localparam logic [D2W-1:0] D2Limit = D2W'(64) << (2 * CoordFracBits);

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic [2:0]               a_radius_class;
    logic [2:0]               b_radius_class;
    logic                     last_pair;
  } in_t;

  typedef struct packed {
    logic signed [OutW-1:0] total_overlap;
    logic                   saturated;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_CHECK,
    ST_SQRT,
    ST_MUL_DQ2,
    ST_MUL_ADQ,
    ST_NUM1,
    ST_NUM2,
    ST_DIV,
    ST_INNER,
    ST_MUL_AI,
    ST_MUL_UC,
    ST_DIV10,
    ST_ACC,
    ST_FINISH,
    ST_MUL_OUT,
    ST_OUT
  } state_e;

  // radius in tenths of an angstrom
  function automatic logic signed [7:0] radius_tenths(input logic [2:0] cls);
    logic signed [7:0] r;
    case (cls)
      3'd1:    r = 8'sd30;
      3'd2:    r = 8'sd40;
      3'd3:    r = 8'sd50;
      3'd4:    r = 8'sd60;
      default: r = -8'sd1;
    endcase
    return r;
  endfunction

  function automatic logic [12:0] radius_sq(input logic [2:0] cls);
    logic [12:0] r;
    case (cls)
      3'd1:    r = 13'd900;
      3'd2:    r = 13'd1600;
      3'd3:    r = 13'd2500;
      3'd4:    r = 13'd3600;
      default: r = 13'd1;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/sphere_overlap_accumulator.sv
`timescale 1ns / 1ps
// sphere_overlap_accumulator: top level, pair sequencer, running sum and result register.
// Depends on soa_pkg, soa_mul, soa_div, soa_sqrt.
//
//  channel  | signals                          | beat
//  ---------+----------------------------------+-----------------------------------
//  in       | in_valid_i, in_ready_o, in_data_i   | one atom pair (soa_pkg::in_t)
//  out      | out_valid_o, out_ready_i, out_data_o| normalised total (soa_pkg::out_t)
//  cfg      | cfg_we_i, cfg_wdata_i              | inv_carbon_area, no wait
//
// One pair at a time. A skipped pair runs three serial squares; a scored pair
// also runs the two serial divisions, the 19-step root and the serial multiplies.
// A last pair adds the output multiply. Reset clears the sum, flags and FSM;
// inv_carbon_area resets to 4096. The next pair is taken while a result waits
// in the output register.
module sphere_overlap_accumulator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  soa_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output soa_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [soa_pkg::InvW-1:0]   cfg_wdata_i
);

  soa_pkg::state_e state_q, state_d;

  logic                          op_busy_q;
  logic [soa_pkg::InvW-1:0]      inv_q;
  logic [soa_pkg::SumW-1:0]      sum_q;
  logic                          ovf_q;
  logic                          out_valid_q;
  soa_pkg::out_t                 out_q;

  logic [soa_pkg::SmallW-1:0]    dxa_q, dya_q, dza_q;
  logic                          gate_q;
  logic                          last_q;
  logic signed [7:0]             ar_q;
  logic signed [7:0]             t_q;
  logic signed [13:0]            sqdiff_q;
  logic [soa_pkg::D2W-1:0]       d2_q;
  logic [soa_pkg::RootW-1:0]     dq_q;
  logic [2*soa_pkg::RootW-1:0]   dqsq_q;
  logic [soa_pkg::AdqW-1:0]      adq_q;
  logic signed [soa_pkg::NumW-1:0] term_q, dq50_q, num_q;
  logic [soa_pkg::DivDW-1:0]     den_q;
  logic [soa_pkg::InnerW-1:0]    inner_q;
  logic                          pneg_q;

  logic                          in_acc;
  logic                          is_mul, is_div, is_sqrt;
  logic                          mul_start, div_start, sqrt_start;
  logic                          mul_done, div_done, sqrt_done, op_done;
  logic [soa_pkg::MulAW-1:0]     mul_a;
  logic [soa_pkg::MulBW-1:0]     mul_b;
  logic [soa_pkg::MulPW-1:0]     mul_prod;
  logic [soa_pkg::DivNW-1:0]     div_num;
  logic [soa_pkg::DivDW-1:0]     div_den;
  logic [soa_pkg::DivNW-1:0]     div_quo;
  logic [soa_pkg::DivDW-1:0]     div_rem;
  logic [soa_pkg::SqrtInW-1:0]   sqrt_rad;
  logic [soa_pkg::RootW-1:0]     sqrt_root;
  logic                          out_load;

  logic signed [soa_pkg::DiffW-1:0] dx, dy, dz;
  logic [soa_pkg::DiffW-1:0]     mx, my, mz;
  logic                          a_neg;
  logic [5:0]                    a_mag;
  logic [13:0]                   tsq;
  logic [soa_pkg::CmpW-1:0]      lhs, rhs;
  logic                          pass;
  logic [soa_pkg::NumW-1:0]      t1;
  logic [soa_pkg::NumW-1:0]      num_mag;
  logic                          num_neg;
  logic [soa_pkg::SumW:0]        qx, ns;
  logic [soa_pkg::SumW-1:0]      sum_mag;
  logic                          sum_neg, frac_nz, sat_hi, sat_lo;
  logic [soa_pkg::SumW:0]        rmag;
  logic [soa_pkg::OutW-1:0]      r_lo;

  // ---- input decode
  assign dx = soa_pkg::DiffW'(in_data_i.a_x) - soa_pkg::DiffW'(in_data_i.b_x);
  assign dy = soa_pkg::DiffW'(in_data_i.a_y) - soa_pkg::DiffW'(in_data_i.b_y);
  assign dz = soa_pkg::DiffW'(in_data_i.a_z) - soa_pkg::DiffW'(in_data_i.b_z);
  assign mx = dx[soa_pkg::DiffW-1] ? -dx : dx;
  assign my = dy[soa_pkg::DiffW-1] ? -dy : dy;
  assign mz = dz[soa_pkg::DiffW-1] ? -dz : dz;

  assign a_neg = ar_q[7];
  assign a_mag = a_neg ? 6'(-ar_q) : ar_q[5:0];

  // ---- range and overlap tests
  assign tsq  = 14'(t_q[6:0]) * 14'(t_q[6:0]);
  assign lhs  = (soa_pkg::CmpW'(d2_q) << 6) + (soa_pkg::CmpW'(d2_q) << 5)
              + (soa_pkg::CmpW'(d2_q) << 2);
  assign rhs  = soa_pkg::CmpW'(tsq) << (2 * soa_pkg::CoordFracBits);
  assign pass = gate_q && (d2_q != '0) && (d2_q < soa_pkg::D2Limit)
              && !t_q[7] && (t_q != '0) && (lhs < rhs);

  assign t1      = (soa_pkg::NumW'(adq_q) << 19) + (soa_pkg::NumW'(adq_q) << 17);
  assign num_neg = num_q[soa_pkg::NumW-1];
  assign num_mag = num_neg ? soa_pkg::NumW'(-num_q) : soa_pkg::NumW'(num_q);

  // ---- accumulate
  assign qx = {1'b0, div_quo};
  assign ns = {sum_q[soa_pkg::SumW-1], sum_q} + (pneg_q ? -qx : qx);

  // ---- normalise: floor(sum * inv / 2^16)
  assign sum_neg = sum_q[soa_pkg::SumW-1];
  assign sum_mag = sum_neg ? -sum_q : sum_q;
  assign frac_nz = |mul_prod[15:0];
  assign rmag    = {1'b0, mul_prod[soa_pkg::MulPW-1:16]} + (soa_pkg::SumW+1)'(sum_neg && frac_nz);
  assign sat_hi  = !sum_neg && (rmag > (soa_pkg::SumW+1)'(32'h7FFF_FFFF));
  assign sat_lo  = sum_neg && (rmag > (soa_pkg::SumW+1)'(32'h8000_0000));
  assign r_lo    = sum_neg ? -rmag[soa_pkg::OutW-1:0] : rmag[soa_pkg::OutW-1:0];

  // ---- shared serial units
  assign op_done = mul_done | div_done | sqrt_done;

  soa_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  soa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  soa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // ---- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      soa_pkg::ST_IDLE:    if (in_valid_i) state_d = soa_pkg::ST_SQ_X;
      soa_pkg::ST_SQ_X:    if (op_done) state_d = soa_pkg::ST_SQ_Y;
      soa_pkg::ST_SQ_Y:    if (op_done) state_d = soa_pkg::ST_SQ_Z;
      soa_pkg::ST_SQ_Z:    if (op_done) state_d = soa_pkg::ST_CHECK;
      soa_pkg::ST_CHECK:   state_d = pass ? soa_pkg::ST_SQRT : soa_pkg::ST_FINISH;
      soa_pkg::ST_SQRT:    if (op_done) state_d = soa_pkg::ST_MUL_DQ2;
      soa_pkg::ST_MUL_DQ2: if (op_done) state_d = soa_pkg::ST_MUL_ADQ;
      soa_pkg::ST_MUL_ADQ: if (op_done) state_d = soa_pkg::ST_NUM1;
      soa_pkg::ST_NUM1:    state_d = soa_pkg::ST_NUM2;
      soa_pkg::ST_NUM2:    state_d = soa_pkg::ST_DIV;
      soa_pkg::ST_DIV:     if (op_done) state_d = soa_pkg::ST_INNER;
      soa_pkg::ST_INNER:   state_d = soa_pkg::ST_MUL_AI;
      soa_pkg::ST_MUL_AI:  if (op_done) state_d = soa_pkg::ST_MUL_UC;
      soa_pkg::ST_MUL_UC:  if (op_done) state_d = soa_pkg::ST_DIV10;
      soa_pkg::ST_DIV10:   if (op_done) state_d = soa_pkg::ST_ACC;
      soa_pkg::ST_ACC:     state_d = soa_pkg::ST_FINISH;
      soa_pkg::ST_FINISH:  state_d = last_q ? soa_pkg::ST_MUL_OUT : soa_pkg::ST_IDLE;
      soa_pkg::ST_MUL_OUT: if (op_done) state_d = soa_pkg::ST_OUT;
      soa_pkg::ST_OUT:     if (!out_valid_q || out_ready_i) state_d = soa_pkg::ST_IDLE;
      default:             state_d = soa_pkg::ST_IDLE;
    endcase
  end

  // ---- outputs and operand selection
  always_comb begin
    in_ready_o = 1'b0;
    is_mul     = 1'b0;
    is_div     = 1'b0;
    is_sqrt    = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_num    = '0;
    div_den    = '0;
    sqrt_rad   = soa_pkg::SqrtInW'(d2_q[soa_pkg::D2W-3:0]) << soa_pkg::SqrtShift;
    case (state_q)
      soa_pkg::ST_IDLE:    in_ready_o = 1'b1;
      soa_pkg::ST_SQ_X: begin
        is_mul = 1'b1;
        mul_a  = soa_pkg::MulAW'(dxa_q);
        mul_b  = soa_pkg::MulBW'(dxa_q);
      end
      soa_pkg::ST_SQ_Y: begin
        is_mul = 1'b1;
        mul_a  = soa_pkg::MulAW'(dya_q);
        mul_b  = soa_pkg::MulBW'(dya_q);
      end
      soa_pkg::ST_SQ_Z: begin
        is_mul = 1'b1;
        mul_a  = soa_pkg::MulAW'(dza_q);
        mul_b  = soa_pkg::MulBW'(dza_q);
      end
      soa_pkg::ST_SQRT:    is_sqrt = 1'b1;
      soa_pkg::ST_MUL_DQ2: begin
        is_mul = 1'b1;
        mul_a  = soa_pkg::MulAW'(dq_q);
        mul_b  = soa_pkg::MulBW'(dq_q);
      end
      soa_pkg::ST_MUL_ADQ: begin
        is_mul = 1'b1;
        mul_a  = soa_pkg::MulAW'(dq_q);
        mul_b  = soa_pkg::MulBW'(a_mag);
      end
      soa_pkg::ST_DIV: begin
        is_div  = 1'b1;
        div_num = num_mag;
        div_den = den_q;
      end
      soa_pkg::ST_MUL_AI: begin
        is_mul = 1'b1;
        mul_a  = soa_pkg::MulAW'(inner_q);
        mul_b  = soa_pkg::MulBW'(a_mag);
      end
      soa_pkg::ST_MUL_UC: begin
        is_mul = 1'b1;
        mul_a  = mul_prod[soa_pkg::MulAW-1:0];
        mul_b  = soa_pkg::MulBW'(soa_pkg::TwoPiQ20);
      end
      soa_pkg::ST_DIV10: begin
        is_div  = 1'b1;
        div_num = soa_pkg::DivNW'(mul_prod[soa_pkg::MulPW-1:20]);
        div_den = soa_pkg::DivDW'(10);
      end
      soa_pkg::ST_MUL_OUT: begin
        is_mul = 1'b1;
        mul_a  = sum_mag;
        mul_b  = soa_pkg::MulBW'(inv_q);
      end
      soa_pkg::ST_OUT:     out_load = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
    mul_start  = is_mul && !op_busy_q;
    div_start  = is_div && !op_busy_q;
    sqrt_start = is_sqrt && !op_busy_q;
  end

  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= soa_pkg::ST_IDLE;
      op_busy_q   <= 1'b0;
      inv_q       <= soa_pkg::InvReset;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_start || div_start || sqrt_start) begin
        op_busy_q <= 1'b1;
      end else if (op_done) begin
        op_busy_q <= 1'b0;
      end
      if (cfg_we_i) begin
        inv_q <= cfg_wdata_i;
      end
      if (state_q == soa_pkg::ST_ACC) begin
        if (ns[soa_pkg::SumW] != ns[soa_pkg::SumW-1]) begin
          sum_q <= ns[soa_pkg::SumW] ? {1'b1, {(soa_pkg::SumW-1){1'b0}}}
                                     : {1'b0, {(soa_pkg::SumW-1){1'b1}}};
          ovf_q <= 1'b1;
        end else begin
          sum_q <= ns[soa_pkg::SumW-1:0];
        end
      end
      if (out_load) begin
        sum_q       <= '0;
        ovf_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dxa_q    <= mx[soa_pkg::SmallW-1:0];
      dya_q    <= my[soa_pkg::SmallW-1:0];
      dza_q    <= mz[soa_pkg::SmallW-1:0];
      gate_q   <= (dx < soa_pkg::DxLimit)
                  && (mx[soa_pkg::DiffW-1:soa_pkg::SmallW] == '0)
                  && (my[soa_pkg::DiffW-1:soa_pkg::SmallW] == '0)
                  && (mz[soa_pkg::DiffW-1:soa_pkg::SmallW] == '0);
      last_q   <= in_data_i.last_pair;
      ar_q     <= soa_pkg::radius_tenths(in_data_i.a_radius_class);
      t_q      <= soa_pkg::radius_tenths(in_data_i.a_radius_class)
                  + soa_pkg::radius_tenths(in_data_i.b_radius_class) - 8'sd6;
      sqdiff_q <= $signed({1'b0, soa_pkg::radius_sq(in_data_i.a_radius_class)})
                  - $signed({1'b0, soa_pkg::radius_sq(in_data_i.b_radius_class)});
    end
    if (op_done) begin
      case (state_q)
        soa_pkg::ST_SQ_X:    d2_q   <= soa_pkg::D2W'(mul_prod[2*soa_pkg::SmallW-1:0]);
        soa_pkg::ST_SQ_Y,
        soa_pkg::ST_SQ_Z:    d2_q   <= d2_q + soa_pkg::D2W'(mul_prod[2*soa_pkg::SmallW-1:0]);
        soa_pkg::ST_SQRT:    dq_q   <= sqrt_root;
        soa_pkg::ST_MUL_DQ2: dqsq_q <= mul_prod[2*soa_pkg::RootW-1:0];
        soa_pkg::ST_MUL_ADQ: adq_q  <= mul_prod[soa_pkg::AdqW-1:0];
        default: begin
        end
      endcase
    end
    if (state_q == soa_pkg::ST_NUM1) begin
      term_q <= a_neg ? -t1 : t1;
      dq50_q <= (soa_pkg::NumW'(dqsq_q) << 5) + (soa_pkg::NumW'(dqsq_q) << 4)
              + (soa_pkg::NumW'(dqsq_q) << 1);
      den_q  <= (soa_pkg::DivDW'(dq_q) << 6) + (soa_pkg::DivDW'(dq_q) << 5)
              + (soa_pkg::DivDW'(dq_q) << 2);
    end
    if (state_q == soa_pkg::ST_NUM2) begin
      num_q <= term_q - dq50_q - (soa_pkg::NumW'(sqdiff_q) <<< 31);
    end
    if (state_q == soa_pkg::ST_INNER) begin
      inner_q <= div_quo[soa_pkg::InnerW-1:0]
                 + soa_pkg::InnerW'(num_neg && (div_rem != '0));
      pneg_q  <= a_neg ^ num_neg;
    end
    if (out_load) begin
      out_q.total_overlap <= sat_hi ? 32'sh7FFF_FFFF
                           : (sat_lo ? 32'sh8000_0000 : $signed(r_lo));
      out_q.saturated     <= ovf_q | sat_hi | sat_lo;
    end
  end

endmodule

// File: rtl/soa_mul.sv
`timescale 1ns / 1ps
// soa_mul: bit-serial shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on soa_pkg.
module soa_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [soa_pkg::MulAW-1:0]  a_i,
  input  logic [soa_pkg::MulBW-1:0]  b_i,
  output logic                       done_o,
  output logic [soa_pkg::MulPW-1:0]  prod_o
);

  logic                      busy_q;
  logic [soa_pkg::MulPW-1:0] acc_q;
  logic [soa_pkg::MulPW-1:0] mcand_q;
  logic [soa_pkg::MulBW-1:0] mplr_q;

  assign done_o = busy_q && (mplr_q == '0);
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= '0;
      mcand_q <= soa_pkg::MulPW'(a_i);
      mplr_q  <= b_i;
    end else if (busy_q && !done_o) begin
      if (mplr_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q <= mcand_q << 1;
      mplr_q  <= mplr_q >> 1;
    end
  end

endmodule

// File: rtl/soa_div.sv
`timescale 1ns / 1ps
// soa_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on soa_pkg.
module soa_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [soa_pkg::DivNW-1:0]  num_i,
  input  logic [soa_pkg::DivDW-1:0]  den_i,
  output logic                       done_o,
  output logic [soa_pkg::DivNW-1:0]  quo_o,
  output logic [soa_pkg::DivDW-1:0]  rem_o
);

  logic                        busy_q;
  logic [soa_pkg::DivCntW-1:0] cnt_q;
  logic [soa_pkg::DivNW-1:0]   quo_q;
  logic [soa_pkg::DivDW-1:0]   rem_q;
  logic [soa_pkg::DivDW-1:0]   den_q;
  logic [soa_pkg::DivDW:0]     shifted;
  logic [soa_pkg::DivDW+1:0]   diff;

  assign shifted = {rem_q, quo_q[soa_pkg::DivNW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign done_o  = busy_q && (cnt_q == '0);
  assign quo_o   = quo_q;
  assign rem_o   = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= soa_pkg::DivCntW'(soa_pkg::DivNW);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && !done_o) begin
      if (!diff[soa_pkg::DivDW+1]) begin
        rem_q <= diff[soa_pkg::DivDW-1:0];
        quo_q <= {quo_q[soa_pkg::DivNW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[soa_pkg::DivDW-1:0];
        quo_q <= {quo_q[soa_pkg::DivNW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/soa_sqrt.sv
`timescale 1ns / 1ps
// soa_sqrt: digit-by-digit integer square root, two radicand bits per cycle.
// Depends on soa_pkg.
module soa_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [soa_pkg::SqrtInW-1:0]  rad_i,
  output logic                         done_o,
  output logic [soa_pkg::RootW-1:0]    root_o
);

  logic                         busy_q;
  logic [soa_pkg::RootCntW-1:0] cnt_q;
  logic [soa_pkg::SqrtInW-1:0]  rad_q;
  logic [soa_pkg::RootW+1:0]    rem_q;
  logic [soa_pkg::RootW-1:0]    root_q;
  logic [soa_pkg::RootW+3:0]    remx;
  logic [soa_pkg::RootW+4:0]    diff;

  assign remx   = {rem_q, rad_q[soa_pkg::SqrtInW-1 -: 2]};
  assign diff   = {1'b0, remx} - (soa_pkg::RootW+5)'({root_q, 2'b01});
  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= soa_pkg::RootCntW'(soa_pkg::RootW);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q && !done_o) begin
      rad_q <= rad_q << 2;
      if (!diff[soa_pkg::RootW+4]) begin
        rem_q  <= diff[soa_pkg::RootW+1:0];
        root_q <= {root_q[soa_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q  <= remx[soa_pkg::RootW+1:0];
        root_q <= {root_q[soa_pkg::RootW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: bench/sphere_overlap_accumulator_tb.sv
`timescale 1ns / 1ps
// sphere_overlap_accumulator_tb: random and directed atom-pair beats, overlap score
// prediction and checking of the normalised totals. Depends on soa_pkg and the RTL.
module sphere_overlap_accumulator_tb;
  import soa_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [InvW-1:0] cfg_wdata_i = '0;

  sphere_overlap_accumulator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  in_t pair_q[$];
  out_t total_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  longint cycles = 0;
  logic [InvW-1:0] inv_area = InvReset;
  longint sum_acc = 0;
  bit ovf_seen = 0;

  localparam longint SumMax = 64'sd140737488355327;
  localparam longint SumMin = -64'sd140737488355328;

  function automatic longint fdiv(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint radius_of(logic [2:0] cls);
    case (cls)
      3'd1: return 30;
      3'd2: return 40;
      3'd3: return 50;
      3'd4: return 60;
      default: return -1;
    endcase
  endfunction

  function automatic longint overlap_term(longint a, longint b, longint d2);
    longint dq, num, inner, p;
    longint unsigned u, hi, lo, q;
    bit neg;
    dq = int_sqrt(longint'(d2) << (32 - 2 * CoordFracBits));
    num = a * 10 * dq * 65536 - 50 * dq * dq - (a * a - b * b) * (64'sd1 << 31);
    inner = fdiv(num, 100 * dq);
    p = a * inner;
    neg = p < 0;
    u = neg ? 64'd0 - longint'(p) : p;
    hi = (u >> 20) * 64'd6588397;
    lo = (u & 64'hFFFFF) * 64'd6588397;
    q = hi / 10 + (((hi % 10) << 20) + lo) / (64'd10 << 20);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  task automatic score_pair(in_t p);
    longint dx, dy, dz, d2, a, b, t, ns, r;
    out_t o;
    dx = longint'(p.a_x) - longint'(p.b_x);
    dy = longint'(p.a_y) - longint'(p.b_y);
    dz = longint'(p.a_z) - longint'(p.b_z);
    if (dx < (64'sd2 << CoordFracBits)) begin
      d2 = dx * dx + dy * dy + dz * dz;
      if (d2 > 0 && d2 < (64'sd64 << (2 * CoordFracBits))) begin
        a = radius_of(p.a_radius_class);
        b = radius_of(p.b_radius_class);
        t = a + b - 6;
        if (t > 0 && 100 * d2 < ((t * t) << (2 * CoordFracBits))) begin
          ns = sum_acc + overlap_term(a, b, d2);
          if (ns > SumMax) begin
            ns = SumMax;
            ovf_seen = 1;
          end else if (ns < SumMin) begin
            ns = SumMin;
            ovf_seen = 1;
          end
          sum_acc = ns;
        end
      end
    end
    if (p.last_pair) begin
      r = fdiv(sum_acc * longint'({48'd0, inv_area}), 65536);
      o.saturated = ovf_seen;
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        o.saturated = 1;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        o.saturated = 1;
      end
      o.total_overlap = r[31:0];
      total_q.insert(total_q.size(), o);
      sum_acc = 0;
      ovf_seen = 0;
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (pair_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_data_i <= pair_q[0];
          score_pair(pair_q.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (total_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = total_q.pop_front();
        if (out_data_o.total_overlap !== want.total_overlap) begin
          $error("total_overlap expected %0d actual %0d", want.total_overlap,
                 out_data_o.total_overlap);
          errors++;
        end
        if (out_data_o.saturated !== want.saturated) begin
          $error("saturated expected %0b actual %0b", want.saturated,
                 out_data_o.saturated);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [CoordW-1:0] near(logic signed [CoordW-1:0] base);
    return base + CoordW'($urandom_range(4096) - 2048);
  endfunction

  function automatic in_t rand_pair(bit wild);
    in_t p;
    p.a_x = CoordW'($urandom);
    p.a_y = CoordW'($urandom);
    p.a_z = CoordW'($urandom);
    if (wild) begin
      p.b_x = CoordW'($urandom);
      p.b_y = CoordW'($urandom);
      p.b_z = CoordW'($urandom);
    end else begin
      p.b_x = near(p.a_x);
      p.b_y = near(p.a_y);
      p.b_z = near(p.a_z);
    end
    p.a_radius_class = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4, 1));
    p.b_radius_class = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4, 1));
    p.last_pair = ($urandom_range(7) == 0);
    return p;
  endfunction

  function automatic in_t mk(int ax, int ay, int az, int bx, int by, int bz,
                             int ca, int cb, bit last);
    in_t p;
    p.a_x = CoordW'(ax); p.a_y = CoordW'(ay); p.a_z = CoordW'(az);
    p.b_x = CoordW'(bx); p.b_y = CoordW'(by); p.b_z = CoordW'(bz);
    p.a_radius_class = 3'(ca); p.b_radius_class = 3'(cb); p.last_pair = last;
    return p;
  endfunction

  task automatic add_pair(in_t p);
    pair_q.insert(pair_q.size(), p);
  endtask

  task automatic drain();
    while (pair_q.size() != 0 || total_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_area(logic [InvW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    inv_area = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [InvW-1:0] areas [5];
    areas = '{16'd1, 16'd65535, 16'd4096, 16'($urandom_range(65535, 1)), 16'd30000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, skip paths, default radius, class 5..7, skipped last
    add_pair(mk(0, 0, 0, 0, 0, 0, 4, 4, 1));
    add_pair(mk(0, 0, 0, 256, 0, 0, 4, 4, 0));
    add_pair(mk(0, 0, 0, 0, 0, 256, 1, 4, 0));
    add_pair(mk(0, 0, 0, 0, 1, 0, 4, 1, 1));
    add_pair(mk(600, 0, 0, 0, 0, 0, 4, 4, 1));
    add_pair(mk(512, 0, 0, 0, 0, 0, 4, 4, 0));
    add_pair(mk(511, 0, 0, 0, 0, 0, 4, 4, 1));
    add_pair(mk(0, 0, 0, 0, 2048, 0, 4, 4, 1));
    add_pair(mk(0, 0, 0, 0, 2047, 0, 4, 4, 1));
    add_pair(mk(0, 0, 0, 0, 200, 0, 0, 4, 0));
    add_pair(mk(0, 0, 0, 0, 200, 0, 4, 0, 0));
    add_pair(mk(0, 0, 0, 0, 100, 0, 5, 7, 0));
    add_pair(mk(0, 0, 0, 0, 100, 0, 6, 3, 1));
    add_pair(mk(-524288, -524288, -524288, 524287, 524287, 524287, 4, 4, 1));
    add_pair(mk(524287, 524287, 524287, -524288, -524288, -524288, 4, 4, 1));
    add_pair(mk(-524288, 524287, 0, -524288, 524287, 10, 1, 1, 0));
    add_pair(mk(524287, -524288, 0, 524287, -524288, 1, 2, 3, 1));
    for (int i = 0; i < 40; i++) add_pair(mk(0, 0, 0, 0, 1, 0, 4, 4, i == 39));
    drain();
    foreach (areas[k]) begin
      write_area(areas[k]);
      case (k % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 47; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 47; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      for (int i = 0; i < 260; i++) begin
        add_pair(rand_pair($urandom_range(9) == 0));
        if ($urandom_range(24) == 0)
          add_pair(mk(0, 0, 0, 0, 1, 0, 4, 4, 0));
      end
      add_pair(rand_pair(0));
      pair_q[$].last_pair = 1'b1;
      drain();
    end
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
